/* src/rmts_pkg.sv */
// Package with the shared types and constants of the rate-monotonic tick scheduler.
`timescale 1ns / 1ps
package rmts_pkg;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 176;
  localparam int unsigned MaskW    = 8;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [1:0] KIND_CONT   = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_RESUME = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RUN,
    ST_DEADLINE,
    ST_SUM,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic clr;
    logic scan;
    logic run;
    logic dl;
    logic sum;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_full;
    logic out_take;
  } dp_status_t;

endpackage

/* src/rmts_ctrl.sv */
// Controller state machine that sequences the slot passes of each item.
`timescale 1ns / 1ps
module rmts_ctrl #(
  parameter int unsigned MAX_TASKS = 8,
  parameter int unsigned IdxW      = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                req_type_i,
  output logic                in_ready_o,
  input  rmts_pkg::dp_status_t status_i,
  output rmts_pkg::ctrl_cmd_t cmd_o,
  output logic [IdxW-1:0]     idx_o
);

  rmts_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             last;

  assign last  = (idx_q == IdxW'(MAX_TASKS - 1));
  assign idx_o = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmts_pkg::ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      rmts_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        idx_d      = '0;
        if (in_valid_i) begin
          cmd_o.clr = 1'b1;
          if (req_type_i == rmts_pkg::REQ_LOAD) begin
            cmd_o.load = 1'b1;
            state_d    = rmts_pkg::ST_SUM;
          end else begin
            state_d = rmts_pkg::ST_SCAN;
          end
        end
      end
      rmts_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (last) begin
          idx_d   = '0;
          state_d = rmts_pkg::ST_RUN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      rmts_pkg::ST_RUN: begin
        cmd_o.run = 1'b1;
        state_d   = rmts_pkg::ST_DEADLINE;
      end
      rmts_pkg::ST_DEADLINE: begin
        cmd_o.dl = 1'b1;
        if (last) begin
          idx_d   = '0;
          state_d = rmts_pkg::ST_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      rmts_pkg::ST_SUM: begin
        cmd_o.sum = 1'b1;
        if (last) begin
          idx_d   = '0;
          state_d = rmts_pkg::ST_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      rmts_pkg::ST_DONE: begin
        if (!status_i.out_full || status_i.out_take) begin
          cmd_o.out_load = 1'b1;
          state_d        = rmts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rmts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/rmts_datapath.sv */
// Datapath with the task table, counters, selection and result register.
`timescale 1ns / 1ps
module rmts_datapath #(
  parameter int unsigned MAX_TASKS = 8,
  parameter int unsigned IdxW      = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rmts_pkg::ctrl_cmd_t            cmd_i,
  input  logic [IdxW-1:0]                idx_i,
  output rmts_pkg::dp_status_t           status_o,
  input  logic                           req_type_i,
  input  logic [2:0]                     slot_i,
  input  logic [15:0]                    task_id_i,
  input  logic [15:0]                    exec_time_i,
  input  logic [15:0]                    period_i,
  input  logic [15:0]                    job_count_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rmts_pkg::OutDataW-1:0]  out_data_o
);

  logic [15:0] ident_q  [MAX_TASKS];
  logic [15:0] exec_q   [MAX_TASKS];
  logic [15:0] per_q    [MAX_TASKS];
  logic [31:0] dl_q     [MAX_TASKS];
  logic [15:0] rem_q    [MAX_TASKS];
  logic [15:0] jobs_q   [MAX_TASKS];
  logic        rdy_q    [MAX_TASKS];
  logic [31:0] wait_q   [MAX_TASKS];

  logic [31:0]     clk_q, done_q, missed_q;
  logic            cur_vld_q, sw_q;
  logic [IdxW-1:0] cur_q, sel_q;
  logic            found_q, is_tick_q;
  logic [15:0]     best_per_q, sel_ident_q, sel_rem_q, sel_exec_q, cur_ident_q;

  logic                r_busy_q, r_pre_q, r_fin_q, all_q;
  logic [15:0]         r_run_id_q, r_pre_id_q;
  logic [1:0]          r_kind_q;
  logic [rmts_pkg::MaskW-1:0] mask_q;
  logic [31:0]         sum_q;

  logic                out_valid_q;
  logic [rmts_pkg::OutDataW-1:0] out_data_q;

  // Per-entry views for the passes.
  logic [15:0]     ld_exec, ld_per;
  logic [IdxW-1:0] ld_slot;
  logic            ld_ok;
  logic            cand;
  logic [15:0]     run_rem;
  logic            run_pre;
  logic            d_hit, d_miss, d_rel, d_rdy, d_wait;
  logic [15:0]     d_jobs;
  logic [31:0]     d_wcnt;

  assign ld_exec = (exec_time_i == 16'd0) ? 16'd1 : exec_time_i;
  assign ld_per  = (period_i == 16'd0) ? 16'd1 : period_i;
  assign ld_slot = IdxW'(slot_i);
  assign ld_ok   = (32'(slot_i) < MAX_TASKS);

  assign cand = rdy_q[idx_i] && (rem_q[idx_i] != 16'd0) && (jobs_q[idx_i] != 16'd0);

  assign run_rem = sel_rem_q - 16'd1;
  assign run_pre = cur_vld_q && (cur_q != sel_q);

  always_comb begin
    d_hit  = (jobs_q[idx_i] != 16'd0) && (dl_q[idx_i] == clk_q);
    d_miss = d_hit && rdy_q[idx_i] && (rem_q[idx_i] != 16'd0);
    d_jobs = d_miss ? (jobs_q[idx_i] - 16'd1) : jobs_q[idx_i];
    d_rel  = d_hit && !(d_miss && (d_jobs == 16'd0));
    d_rdy  = d_rel ? 1'b1 : (d_miss ? 1'b0 : rdy_q[idx_i]);
    d_wait = found_q && (idx_i != sel_q) && d_rdy && (d_jobs != 16'd0);
    d_wcnt = d_wait ? (wait_q[idx_i] + 32'd1) : wait_q[idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        ident_q[i] <= '0;
        exec_q[i]  <= '0;
        per_q[i]   <= '0;
        dl_q[i]    <= '0;
        rem_q[i]   <= '0;
        jobs_q[i]  <= '0;
        rdy_q[i]   <= 1'b0;
        wait_q[i]  <= '0;
      end
      clk_q     <= '0;
      done_q    <= '0;
      missed_q  <= '0;
      cur_vld_q <= 1'b0;
      cur_q     <= '0;
      sw_q      <= 1'b1;
      found_q   <= 1'b0;
      sel_q     <= '0;
      is_tick_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        found_q   <= 1'b0;
        is_tick_q <= (req_type_i == rmts_pkg::REQ_TICK);
      end
      if (cmd_i.load && ld_ok) begin
        ident_q[ld_slot] <= task_id_i;
        exec_q[ld_slot]  <= ld_exec;
        per_q[ld_slot]   <= ld_per;
        dl_q[ld_slot]    <= clk_q + 32'(ld_per);
        rem_q[ld_slot]   <= ld_exec;
        jobs_q[ld_slot]  <= job_count_i;
        rdy_q[ld_slot]   <= (job_count_i != 16'd0);
        wait_q[ld_slot]  <= '0;
        if (cur_vld_q && (cur_q == ld_slot)) begin
          cur_vld_q <= 1'b0;
          sw_q      <= 1'b1;
        end
      end
      if (cmd_i.scan && cand && (!found_q || (per_q[idx_i] < best_per_q))) begin
        found_q <= 1'b1;
        sel_q   <= idx_i;
      end
      if (cmd_i.run) begin
        clk_q <= clk_q + 32'd1;
        if (found_q) begin
          rem_q[sel_q] <= run_rem;
          if (run_rem == 16'd0) begin
            done_q        <= done_q + 32'd1;
            rdy_q[sel_q]  <= 1'b0;
            jobs_q[sel_q] <= jobs_q[sel_q] - 16'd1;
            sw_q          <= 1'b1;
            cur_vld_q     <= 1'b0;
          end else begin
            sw_q      <= 1'b0;
            cur_vld_q <= 1'b1;
            cur_q     <= sel_q;
          end
        end
      end
      if (cmd_i.dl) begin
        jobs_q[idx_i] <= d_jobs;
        rdy_q[idx_i]  <= d_rdy;
        wait_q[idx_i] <= d_wcnt;
        if (d_miss) begin
          missed_q <= missed_q + 32'd1;
          if (found_q && (idx_i == sel_q)) begin
            sw_q      <= 1'b1;
            cur_vld_q <= 1'b0;
          end
        end
        if (d_rel) begin
          dl_q[idx_i]  <= dl_q[idx_i] + 32'(per_q[idx_i]);
          rem_q[idx_i] <= exec_q[idx_i];
        end
      end
    end
  end

  // Per-item scratch and result fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      r_busy_q   <= 1'b0;
      r_pre_q    <= 1'b0;
      r_fin_q    <= 1'b0;
      r_run_id_q <= '0;
      r_pre_id_q <= '0;
      r_kind_q   <= rmts_pkg::KIND_CONT;
      mask_q     <= '0;
      sum_q      <= '0;
      all_q      <= 1'b1;
    end
    if (cmd_i.scan) begin
      if (cand && (!found_q || (per_q[idx_i] < best_per_q))) begin
        best_per_q  <= per_q[idx_i];
        sel_ident_q <= ident_q[idx_i];
        sel_rem_q   <= rem_q[idx_i];
        sel_exec_q  <= exec_q[idx_i];
      end
      if (cur_vld_q && (cur_q == idx_i)) begin
        cur_ident_q <= ident_q[idx_i];
      end
    end
    if (cmd_i.run && found_q) begin
      r_busy_q   <= 1'b1;
      r_run_id_q <= sel_ident_q;
      r_pre_q    <= run_pre;
      r_pre_id_q <= run_pre ? cur_ident_q : 16'd0;
      if (sw_q || run_pre) begin
        r_kind_q <= (sel_rem_q == sel_exec_q) ? rmts_pkg::KIND_START : rmts_pkg::KIND_RESUME;
      end
      r_fin_q <= (run_rem == 16'd0);
    end
    if (cmd_i.dl) begin
      sum_q <= sum_q + d_wcnt;
      all_q <= all_q && (d_jobs == 16'd0);
      for (int b = 0; b < rmts_pkg::MaskW; b++) begin
        if (d_miss && (32'(idx_i) == b)) begin
          mask_q[b] <= 1'b1;
        end
      end
    end
    if (cmd_i.sum) begin
      sum_q <= sum_q + wait_q[idx_i];
      all_q <= all_q && (jobs_q[idx_i] == 16'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {2'b00, sum_q, missed_q, done_q, all_q,
                     is_tick_q ? mask_q : 8'd0, r_fin_q, r_kind_q,
                     r_pre_id_q, r_pre_q, r_run_id_q, r_busy_q, clk_q};
    end
  end

  assign status_o.out_full = out_valid_q;
  assign status_o.out_take = out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

endmodule

/* src/rate_monotonic_tick_scheduler.sv */
// Top level of the rate-monotonic tick scheduler.
// Usage: the slave stream carries requests; tuser selects a load beat (0) that
// fills one task slot from tdata, or a tick beat (1) that advances time by one
// tick. Every accepted beat yields exactly one result beat on the master
// stream, holding the tick counter, the task that ran, preemption, start or
// resume, finish, the deadline-miss mask and the running totals.
// Sequence: a tick runs a selection pass over all slots, a run step, a deadline
// pass over all slots and a result step before its result is valid; a load runs
// a totals pass over all slots before its result step. The slot passes read one
// table entry per cycle, and a new request is not accepted until the controller
// is back in idle with the previous item finished.
// The result sits in an output register, so a new request is accepted while
// the previous result still waits; if the receiver stalls, the next result
// waits in the controller until the register frees up.
// Reset empties every slot, zeros the clock and the totals, and marks that
// no task is running.
`timescale 1ns / 1ps
module rate_monotonic_tick_scheduler #(
  parameter int unsigned MAX_TASKS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // slot[2:0], task_id[18:3], exec_time[34:19], period[50:35], job_count[66:51]
  input  logic [rmts_pkg::InDataW-1:0]  s_axis_tdata_i,
  // req_type[0]
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // time_now[31:0], busy_res[32], running_id[48:33], preempt[49],
  // preempted_id[65:50], start_kind[67:66], finished[68], miss_mask[76:69],
  // all_done[77], completed_total[109:78], missed_total[141:110],
  // wait_total[173:142]
  output logic [rmts_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  rmts_pkg::ctrl_cmd_t  cmd;
  rmts_pkg::dp_status_t status;
  logic [IdxW-1:0]      idx;

  rmts_ctrl #(
    .MAX_TASKS(MAX_TASKS),
    .IdxW     (IdxW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .req_type_i(s_axis_tuser_i),
    .in_ready_o(s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd),
    .idx_o     (idx)
  );

  rmts_datapath #(
    .MAX_TASKS(MAX_TASKS),
    .IdxW     (IdxW)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .idx_i      (idx),
    .status_o   (status),
    .req_type_i (s_axis_tuser_i),
    .slot_i     (s_axis_tdata_i[2:0]),
    .task_id_i  (s_axis_tdata_i[18:3]),
    .exec_time_i(s_axis_tdata_i[34:19]),
    .period_i   (s_axis_tdata_i[50:35]),
    .job_count_i(s_axis_tdata_i[66:51]),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (m_axis_tdata_o)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request accepted while a previous one is in progress");

  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[32]) |->
      (m_axis_tdata_o[68:50] == '0 && m_axis_tdata_o[48:33] == '0))
    else $error("idle result reports a running task");

  a_finish_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[68]) |-> m_axis_tdata_o[32])
    else $error("finish reported without a running task");
`endif

endmodule

/* test/rate_monotonic_tick_scheduler_tb.sv */
// Self-checking testbench of the rate-monotonic tick scheduler with its own scheduler model.
`timescale 1ns / 1ps
module rate_monotonic_tick_scheduler_tb;

  localparam int NT = 8;
  localparam longint CycleLimit = 3000000;

  typedef struct packed {
    logic [31:0] wait_total;
    logic [31:0] missed_total;
    logic [31:0] completed_total;
    logic        all_done;
    logic [7:0]  miss_mask;
    logic        finished;
    logic [1:0]  start_kind;
    logic [15:0] preempted_id;
    logic        preempt;
    logic [15:0] running_id;
    logic        busy_res;
    logic [31:0] time_now;
  } sched_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [rmts_pkg::InDataW-1:0] s_axis_tdata_i = '0;
  logic s_axis_tuser_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [rmts_pkg::OutDataW-1:0] m_axis_tdata_o;

  rate_monotonic_tick_scheduler DUT (.*);

  logic [15:0] t_id [NT];
  logic [15:0] t_exec [NT];
  logic [15:0] t_per [NT];
  logic [31:0] t_dl [NT];
  logic [15:0] t_rem [NT];
  logic [15:0] t_jobs [NT];
  logic        t_rdy [NT];
  logic [31:0] t_wait [NT];
  logic [31:0] ticks, done_cnt, miss_cnt;
  int          cur_slot;
  logic        sw_pend;

  sched_res_t pending_res [$];
  int  errors = 0;
  int  send_idle = 0;
  int  recv_stall = 0;
  longint cycles = 0;

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void model_reset();
    for (int i = 0; i < NT; i++) begin
      t_id[i] = 0; t_exec[i] = 0; t_per[i] = 0; t_dl[i] = 0;
      t_rem[i] = 0; t_jobs[i] = 0; t_rdy[i] = 0; t_wait[i] = 0;
    end
    ticks = 0; done_cnt = 0; miss_cnt = 0; cur_slot = NT; sw_pend = 1;
  endfunction

  function automatic sched_res_t schedule_step(logic kind, logic [2:0] s, logic [15:0] id,
                                               logic [15:0] e, logic [15:0] p,
                                               logic [15:0] n);
    sched_res_t r;
    int sel;
    logic [31:0] sum;
    logic all;
    logic rel;
    r = '0;
    sel = NT;
    if (kind == rmts_pkg::REQ_LOAD) begin
      if (e == 0) e = 1;
      if (p == 0) p = 1;
      t_id[s] = id; t_exec[s] = e; t_per[s] = p; t_dl[s] = ticks + p;
      t_rem[s] = e; t_jobs[s] = n; t_rdy[s] = (n != 0); t_wait[s] = 0;
      if (cur_slot == s) begin
        cur_slot = NT; sw_pend = 1;
      end
    end else begin
      for (int i = 0; i < NT; i++)
        if (t_rdy[i] && t_rem[i] != 0 && t_jobs[i] != 0)
          if (sel == NT || t_per[i] < t_per[sel]) sel = i;
      if (sel < NT) begin
        r.busy_res = 1; r.running_id = t_id[sel];
        if (cur_slot < NT && cur_slot != sel) begin
          r.preempt = 1; r.preempted_id = t_id[cur_slot]; sw_pend = 1;
        end
        if (sw_pend) begin
          r.start_kind = (t_rem[sel] == t_exec[sel]) ? rmts_pkg::KIND_START
                                                     : rmts_pkg::KIND_RESUME;
          sw_pend = 0;
        end
        cur_slot = sel;
        t_rem[sel]--;
        if (t_rem[sel] == 0) begin
          r.finished = 1; done_cnt++; t_rdy[sel] = 0; t_jobs[sel]--;
          sw_pend = 1; cur_slot = NT;
        end
      end
      ticks++;
      for (int i = 0; i < NT; i++) begin
        if (t_jobs[i] != 0 && t_dl[i] == ticks) begin
          rel = 1;
          if (t_rdy[i] && t_rem[i] != 0) begin
            miss_cnt++; r.miss_mask[i] = 1; t_jobs[i]--; t_rdy[i] = 0;
            if (i == sel) begin
              sw_pend = 1; cur_slot = NT;
            end
            if (t_jobs[i] == 0) rel = 0;
          end
          if (rel) begin
            t_dl[i] += t_per[i]; t_rem[i] = t_exec[i]; t_rdy[i] = 1;
          end
        end
        if (sel < NT && i != sel && t_rdy[i] && t_jobs[i] != 0) t_wait[i]++;
      end
    end
    sum = 0; all = 1;
    for (int i = 0; i < NT; i++) begin
      sum += t_wait[i];
      if (t_jobs[i] != 0) all = 0;
    end
    r.time_now = ticks; r.all_done = all; r.completed_total = done_cnt;
    r.missed_total = miss_cnt; r.wait_total = sum;
    return r;
  endfunction

  task automatic send_beat(logic kind, logic [2:0] s, logic [15:0] id, logic [15:0] e,
                           logic [15:0] p, logic [15:0] n);
    sched_res_t exp_res;
    while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i = kind;
    s_axis_tdata_i = {5'd0, n, p, e, id, s};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    exp_res = schedule_step(kind, s, id, e, p, n);
    pending_res.insert(pending_res.size(), exp_res);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic load_slot(logic [2:0] s, logic [15:0] id, logic [15:0] e, logic [15:0] p,
                           logic [15:0] n);
    send_beat(rmts_pkg::REQ_LOAD, s, id, e, p, n);
  endtask

  task automatic tick();
    send_beat(rmts_pkg::REQ_TICK, 3'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    while (pending_res.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i)
    m_axis_tready_i <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);

  always @(posedge clk_i) begin
    sched_res_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[173:0];
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        errors++;
      end else begin
        want = pending_res.pop_front();
        if (got !== want || m_axis_tdata_o[175:174] !== 2'b00) begin
          $display("%0t: expected %h actual %h", $time, want, m_axis_tdata_o);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    load_slot(3'd0, 16'h0001, 16'd2, 16'd4, 16'd3);
    load_slot(3'd7, 16'hFFFF, 16'd1, 16'd2, 16'd2);
    load_slot(3'd3, 16'h0033, 16'd0, 16'd0, 16'd1);
    repeat (4) tick();
    load_slot(3'd1, 16'h0011, 16'd3, 16'd2, 16'd4);
    repeat (3) tick();
    load_slot(3'd1, 16'h0012, 16'd1, 16'd3, 16'd1);
    load_slot(3'd2, 16'h0022, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (6) tick();
    load_slot(3'd2, 16'h0000, 16'd1, 16'd1, 16'd0);
    repeat (4) tick();
    drain();
  endtask

  task automatic test_random(int n_items);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(9) < 2)
        case ($urandom_range(5))
          0: load_slot(3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom));
          1: load_slot(3'($urandom), 16'($urandom), 16'(16'hFFFF - $urandom_range(3)),
                       16'(16'hFFFF - $urandom_range(3)),
                       16'(16'hFFFF - $urandom_range(3)));
          default: load_slot(3'($urandom), 16'($urandom), 16'($urandom_range(6)),
                             16'($urandom_range(12)), 16'($urandom_range(6)));
        endcase
      else
        tick();
    end
    drain();
  endtask

  initial begin
    model_reset();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(380);
    send_idle = 82;
    test_random(380);
    send_idle = 0; recv_stall = 82;
    test_random(380);
    send_idle = 34; recv_stall = 34;
    test_random(380);
    drain();
    repeat (60) @(negedge clk_i);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

/* filelist.f */
src/rmts_pkg.sv
src/rmts_ctrl.sv
src/rmts_datapath.sv
src/rate_monotonic_tick_scheduler.sv
test/rate_monotonic_tick_scheduler_tb.sv
